>>> hdl/integer_array_sorter_core_defines.svh
// ----------------------------------------------------------------------------
// Integer array sorter assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_ARRAY_SORTER_CORE_DEFINES_SVH
`define INTEGER_ARRAY_SORTER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IAS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IAS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/ias_pkg.sv
// ----------------------------------------------------------------------------
// Integer array sorter package
// Widths, defaults and the control bundle broadcast along the cell row.
// ----------------------------------------------------------------------------
package ias_pkg;

	localparam int DATA_W        = 32;
	localparam int MAX_ITEMS_DEF = 64;

	typedef logic signed [DATA_W-1:0] data_t;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic  ins;       // insert ins_value into the sorted row
		logic  shl;       // shift the row one place towards the head
		data_t ins_value; // value being inserted
	} cell_ctl_t;

endpackage

>>> hdl/ias_cell.sv
// ----------------------------------------------------------------------------
// Integer array sorter cell
// One slot of the sorted row: keeps its value, takes the new value or takes
// a neighbour's value, so that the row stays in ascending order.
// ----------------------------------------------------------------------------
module ias_cell
	import ias_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      left_le,
	input  data_t     left_value,
	input  logic      left_valid,
	input  data_t     right_value,
	input  logic      right_valid,
	output data_t     value,
	output logic      valid,
	output logic      le
);

	data_t value_q;
	logic  valid_q;

	// The stored value is not above the incoming one, so it stays put.
	assign le    = valid_q && (value_q <= ctl.ins_value);
	assign value = value_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shl) begin
			valid_q <= right_valid;
		end else if (ctl.ins && !le) begin
			valid_q <= left_le ? 1'b1 : left_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shl) begin
			value_q <= right_value;
		end else if (ctl.ins && !le) begin
			value_q <= left_le ? ctl.ins_value : left_value;
		end
	end

endmodule

>>> hdl/ias_ctrl.sv
// ----------------------------------------------------------------------------
// Integer array sorter sequencer
// Counts the loaded values, tracks overflow, drains the row head into the
// output register and runs both request handshakes.
// ----------------------------------------------------------------------------
`include "integer_array_sorter_core_defines.svh"

module ias_ctrl
	import ias_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  data_t     sample_value,
	input  logic      final_item,
	output logic      out_valid,
	input  logic      out_stall,
	output data_t     sorted_value,
	output logic      final_result,
	output logic      dropped_items,
	input  data_t     head_value,
	output cell_ctl_t ctl
);

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] remaining_q;
	logic             ovf_q;
	logic             drop_q;
	logic             drain_q;
	logic             out_valid_q;
	data_t            sorted_value_q;
	logic             final_result_q;
	logic             dropped_items_q;

	logic in_accept;
	logic full;
	logic ins;
	logic load;

	assign in_stall  = drain_q;
	assign in_accept = in_valid && !in_stall;
	assign full      = (count_q == CNT_MAX);
	assign ins       = in_accept && !full;
	assign load      = drain_q && (!out_valid_q || !out_stall);

	assign ctl.ins       = ins;
	assign ctl.shl       = load;
	assign ctl.ins_value = sample_value;

	assign out_valid     = out_valid_q;
	assign sorted_value  = sorted_value_q;
	assign final_result  = final_result_q;
	assign dropped_items = dropped_items_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			remaining_q <= '0;
			ovf_q       <= 1'b0;
			drop_q      <= 1'b0;
			drain_q     <= 1'b0;
		end else if (in_accept) begin
			if (final_item) begin
				drain_q     <= 1'b1;
				remaining_q <= ins ? count_q + CNT_ONE : count_q;
				drop_q      <= ovf_q || full;
				count_q     <= '0;
				ovf_q       <= 1'b0;
			end else begin
				count_q <= ins ? count_q + CNT_ONE : count_q;
				ovf_q   <= ovf_q || full;
			end
		end else if (load) begin
			remaining_q <= remaining_q - CNT_ONE;
			if (remaining_q == CNT_ONE) begin
				drain_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sorted_value_q  <= head_value;
			final_result_q  <= (remaining_q == CNT_ONE);
			dropped_items_q <= drop_q;
		end
	end

	`IAS_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CNT_MAX, "item count beyond capacity")
	`IAS_ASSERT_SAME(a_drain_nonzero, drain_q, remaining_q != '0, "draining with nothing left")
	`IAS_ASSERT_NEXT(a_final_drains, in_accept && final_item, drain_q && count_q == '0,
		"final request did not start the drain")
	`IAS_ASSERT_NEXT(a_last_ends, load && remaining_q == CNT_ONE, !drain_q && final_result_q,
		"last result did not close the set")

endmodule

>>> hdl/integer_array_sorter_core.sv
// ----------------------------------------------------------------------------
// Integer array sorter core
// A set of n values takes n requests, one per cycle; the final request
// starts the drain, which registers each result from the row head into the
// output register, one per cycle while out_stall does not hold it. Input is
// stalled while a set drains. Reset clears all control.
// ----------------------------------------------------------------------------
//
// The sorted row is a chain of MAX_ITEMS cells, kept in ascending order from
// cell 0. Each accepted value is compared against every stored value at once;
// cells holding a larger value, and the empty cells, move one place to the
// right, and the first of them takes the new value. Equal values stay ahead of
// the newcomer, so duplicates are all kept.
//
// Values arriving while the row is full are discarded and the set is marked.
// On the final request the sequencer drains the row through cell 0 into the
// output register, one value per cycle, shifting the whole row towards the
// head each time the register is free. The last result of the set carries
// final_result; dropped_items reports whether the set lost values. The valid
// bits of the cells are reset; the stored values are not, and an empty cell is
// never read out.
// ----------------------------------------------------------------------------
module integer_array_sorter_core
	import ias_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  data_t sample_value,
	input  logic  final_item,
	output logic  out_valid,
	input  logic  out_stall,
	output data_t sorted_value,
	output logic  final_result,
	output logic  dropped_items
);

	cell_ctl_t ctl;

	// Per-cell state visible to the neighbours.
	data_t cell_value [MAX_ITEMS];
	logic  cell_valid [MAX_ITEMS];
	logic  cell_le    [MAX_ITEMS];

	ias_ctrl #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.sample_value  (sample_value),
		.final_item    (final_item),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sorted_value  (sorted_value),
		.final_result  (final_result),
		.dropped_items (dropped_items),
		.head_value    (cell_value[0]),
		.ctl           (ctl)
	);

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic  left_le;
		data_t left_value;
		logic  left_valid;
		data_t right_value;
		logic  right_valid;

		// Cell 0 behaves as if its left neighbour always stays put, so the
		// new value lands there whenever the head holds a larger one or is empty.
		if (i == 0) begin : g_head
			assign left_le    = 1'b1;
			assign left_value = '0;
			assign left_valid = 1'b0;
		end else begin : g_body
			assign left_le    = cell_le[i-1];
			assign left_value = cell_value[i-1];
			assign left_valid = cell_valid[i-1];
		end

		// The tail is refilled with an empty slot while draining.
		if (i == MAX_ITEMS - 1) begin : g_tail
			assign right_value = '0;
			assign right_valid = 1'b0;
		end else begin : g_inner
			assign right_value = cell_value[i+1];
			assign right_valid = cell_valid[i+1];
		end

		ias_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.left_le     (left_le),
			.left_value  (left_value),
			.left_valid  (left_valid),
			.right_value (right_value),
			.right_valid (right_valid),
			.value       (cell_value[i]),
			.valid       (cell_valid[i]),
			.le          (cell_le[i])
		);
	end

endmodule
